// ----- rtl/tfn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_pkg
// Shared types and constants for the triangle face normal pipeline.
// ----------------------------------------------------------------------------
package tfn_pkg;

  localparam int COORD_W   = 32;            // Q16.16 vertex coordinate
  localparam int EDGE_W    = COORD_W + 1;   // exact edge component
  localparam int PM_W      = 31;            // prescaled magnitude
  localparam int ROOT_W    = 32;            // floor(sqrt) of sum of squares
  localparam int SQRT_N    = 32;            // one root bit per stage
  localparam int QUO_W     = 31;            // unit magnitude, Q1.30
  localparam int UNIT_W    = 32;            // signed unit component
  localparam int OUT_W     = 18;            // Q1.16 result
  localparam int FRAC_DROP = 44;            // Q2.60 -> Q1.16
  localparam logic [OUT_W-2:0] NORM_MAX = 17'd65536;

  typedef logic [EDGE_W-1:0] edge_t;
  typedef edge_t [2:0] edge3_t;
  typedef logic [UNIT_W-1:0] unitc_t;
  typedef unitc_t [2:0] unit3_t;

  // Control that travels alongside a pipeline transaction
  typedef struct packed {
    logic valid;
    logic zero;
  } tfn_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/tfn_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_unit
// Scales one 33-bit edge to unit length in Q1.30: prescale, sum of squares,
// pipelined square root, pipelined rounded division. 70 stages.
// ----------------------------------------------------------------------------
module tfn_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              en,
  input  wire logic              in_valid,
  input  wire tfn_pkg::edge3_t   e,
  output tfn_pkg::tfn_ctl_t      out_ctl,
  output tfn_pkg::unit3_t        u
);
  import tfn_pkg::*;

  // Stage 1: magnitudes and largest magnitude
  logic                  v1;
  logic                  zero1;
  logic [2:0]            neg1;
  logic [EDGE_W-1:0]     mag1 [3];
  logic [EDGE_W-1:0]     m1;
  logic [EDGE_W-1:0]     mag_c [3];
  logic [EDGE_W-1:0]     max_c;

  always_comb begin
    max_c = '0;
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = e[i][EDGE_W-1] ? (~e[i] + 1'b1) : e[i];
      if (mag_c[i] > max_c) max_c = mag_c[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid;
    if (en) begin
      zero1 <= (e[0] == '0) && (e[1] == '0) && (e[2] == '0);
      for (int i = 0; i < 3; i++) begin
        neg1[i] <= e[i][EDGE_W-1];
        mag1[i] <= mag_c[i];
      end
      m1 <= max_c;
    end
  end

  // Stage 2: shift amount
  logic                  v2;
  logic                  zero2;
  logic [2:0]            neg2;
  logic [EDGE_W-1:0]     mag2 [3];
  logic                  big2;
  logic [1:0]            rsh2;
  logic [4:0]            lsh2;
  logic [4:0]            msb_c;

  always_comb begin
    msb_c = '0;
    for (int j = 0; j < PM_W; j++) begin
      if (m1[j]) msb_c = 5'(j);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      zero2 <= zero1;
      neg2  <= neg1;
      for (int i = 0; i < 3; i++) mag2[i] <= mag1[i];
      big2  <= m1[EDGE_W-1] || m1[EDGE_W-2];
      rsh2  <= m1[EDGE_W-1] ? 2'd2 : 2'd1;
      lsh2  <= 5'(PM_W - 1) - msb_c;
    end
  end

  // Stage 3: apply prescale
  logic                  v3;
  logic                  zero3;
  logic [2:0]            neg3;
  logic [PM_W-1:0]       pm3 [3];

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
    if (en) begin
      zero3 <= zero2;
      neg3  <= neg2;
      for (int i = 0; i < 3; i++) begin
        if (big2) pm3[i] <= PM_W'(mag2[i] >> rsh2);
        else      pm3[i] <= PM_W'(mag2[i] << lsh2);
      end
    end
  end

  // Stage 4: squares
  logic                  v4;
  logic                  zero4;
  logic [2:0]            neg4;
  logic [PM_W-1:0]       pm4 [3];
  logic [2*PM_W-1:0]     sq4 [3];

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
    if (en) begin
      zero4 <= zero3;
      neg4  <= neg3;
      for (int i = 0; i < 3; i++) begin
        pm4[i] <= pm3[i];
        sq4[i] <= {{PM_W{1'b0}}, pm3[i]} * {{PM_W{1'b0}}, pm3[i]};
      end
    end
  end

  // Stage 5: sum of squares; feeds the root pipeline at index 0
  logic                  sv   [SQRT_N+1];
  logic                  szero[SQRT_N+1];
  logic [2:0]            sneg [SQRT_N+1];
  logic [PM_W-1:0]       spm  [SQRT_N+1][3];
  logic [63:0]           ss   [SQRT_N+1];
  logic [ROOT_W+1:0]     srem [SQRT_N+1];
  logic [ROOT_W-1:0]     sroot[SQRT_N+1];

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else if (en) sv[0] <= v4;
    if (en) begin
      szero[0] <= zero4;
      sneg[0]  <= neg4;
      for (int i = 0; i < 3; i++) spm[0][i] <= pm4[i];
      ss[0]    <= 64'(sq4[0]) + 64'(sq4[1]) + 64'(sq4[2]);
      srem[0]  <= '0;
      sroot[0] <= '0;
    end
  end

  // Square root: one root bit per stage, two radicand bits brought down
  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    logic [ROOT_W+3:0] cur;
    logic [ROOT_W+3:0] trial;
    assign cur   = {srem[k], ss[k][63-2*k -: 2]};
    assign trial = {2'b00, sroot[k], 2'b01};

    always_ff @(posedge clk) begin
      if (rst) sv[k+1] <= 1'b0;
      else if (en) sv[k+1] <= sv[k];
      if (en) begin
        szero[k+1] <= szero[k];
        sneg[k+1]  <= sneg[k];
        for (int i = 0; i < 3; i++) spm[k+1][i] <= spm[k][i];
        ss[k+1] <= ss[k];
        if (cur >= trial) begin
          srem[k+1]  <= (ROOT_W+2)'(cur - trial);
          sroot[k+1] <= {sroot[k][ROOT_W-2:0], 1'b1};
        end else begin
          srem[k+1]  <= (ROOT_W+2)'(cur);
          sroot[k+1] <= {sroot[k][ROOT_W-2:0], 1'b0};
        end
      end
    end
  end

  // Numerator stage feeds the divider at index 0
  localparam int NUM_W = PM_W + 31;
  logic                  dv   [QUO_W+1];
  logic                  dzero[QUO_W+1];
  logic [2:0]            dneg [QUO_W+1];
  logic [ROOT_W-1:0]     dlen [QUO_W+1];
  logic [ROOT_W-1:0]     drem [QUO_W+1][3];
  logic [QUO_W-1:0]      dlow [QUO_W+1][3];
  logic [QUO_W-1:0]      dquo [QUO_W+1][3];
  logic [NUM_W-1:0]      num_c[3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_c[i] = NUM_W'({spm[SQRT_N][i], 30'b0}) + NUM_W'(sroot[SQRT_N][ROOT_W-1:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) dv[0] <= 1'b0;
    else if (en) dv[0] <= sv[SQRT_N];
    if (en) begin
      dzero[0] <= szero[SQRT_N];
      dneg[0]  <= sneg[SQRT_N];
      dlen[0]  <= sroot[SQRT_N];
      for (int i = 0; i < 3; i++) begin
        drem[0][i] <= ROOT_W'(num_c[i][NUM_W-1:QUO_W]);
        dlow[0][i] <= num_c[i][QUO_W-1:0];
        dquo[0][i] <= '0;
      end
    end
  end

  // Restoring division: one quotient bit per stage
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    logic [ROOT_W:0] t [3];
    always_comb begin
      for (int i = 0; i < 3; i++) t[i] = {drem[k][i], dlow[k][i][QUO_W-1-k]};
    end

    always_ff @(posedge clk) begin
      if (rst) dv[k+1] <= 1'b0;
      else if (en) dv[k+1] <= dv[k];
      if (en) begin
        dzero[k+1] <= dzero[k];
        dneg[k+1]  <= dneg[k];
        dlen[k+1]  <= dlen[k];
        for (int i = 0; i < 3; i++) begin
          dlow[k+1][i] <= dlow[k][i];
          if (t[i] >= {1'b0, dlen[k]}) begin
            drem[k+1][i] <= ROOT_W'(t[i] - {1'b0, dlen[k]});
            dquo[k+1][i] <= {dquo[k][i][QUO_W-2:0], 1'b1};
          end else begin
            drem[k+1][i] <= ROOT_W'(t[i]);
            dquo[k+1][i] <= {dquo[k][i][QUO_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  // Apply sign
  always_ff @(posedge clk) begin
    if (rst) out_ctl.valid <= 1'b0;
    else if (en) out_ctl.valid <= dv[QUO_W];
    if (en) begin
      out_ctl.zero <= dzero[QUO_W];
      for (int i = 0; i < 3; i++) begin
        u[i] <= dneg[QUO_W][i] ? (~UNIT_W'(dquo[QUO_W][i]) + 1'b1)
                               : UNIT_W'(dquo[QUO_W][i]);
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tfn_cross.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfn_cross
// Cross product of two Q1.30 unit vectors, rounded to Q1.16 and saturated.
// Three stages: products, differences, round into the output register.
// ----------------------------------------------------------------------------
module tfn_cross (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  en,
  input  wire tfn_pkg::tfn_ctl_t     in_ctl,
  input  wire tfn_pkg::unit3_t       ua,
  input  wire tfn_pkg::unit3_t       ub,
  output logic                       out_valid,
  output logic [tfn_pkg::OUT_W-1:0]  normal_x,
  output logic [tfn_pkg::OUT_W-1:0]  normal_y,
  output logic [tfn_pkg::OUT_W-1:0]  normal_z,
  output logic                       degenerate
);
  import tfn_pkg::*;

  logic               v1, v2;
  logic               dg1, dg2;
  logic signed [63:0] p [6];
  logic signed [63:0] d [3];
  logic [63:0]        mag_c [3];
  logic [63:0]        rnd_c [3];
  logic [OUT_W-2:0]   sat_c [3];
  logic [OUT_W-1:0]   res_c [3];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_ctl.valid;
    if (en) begin
      dg1  <= in_ctl.zero;
      p[0] <= 64'($signed(ua[1])) * 64'($signed(ub[2]));
      p[1] <= 64'($signed(ua[2])) * 64'($signed(ub[1]));
      p[2] <= 64'($signed(ua[2])) * 64'($signed(ub[0]));
      p[3] <= 64'($signed(ua[0])) * 64'($signed(ub[2]));
      p[4] <= 64'($signed(ua[0])) * 64'($signed(ub[1]));
      p[5] <= 64'($signed(ua[1])) * 64'($signed(ub[0]));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
    if (en) begin
      dg2  <= dg1;
      d[0] <= p[0] - p[1];
      d[1] <= p[2] - p[3];
      d[2] <= p[4] - p[5];
    end
  end

  // Round half away from zero, clamp, restore sign
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_c[i] = d[i][63] ? (~d[i] + 1'b1) : d[i];
      rnd_c[i] = (mag_c[i] + (64'd1 << (FRAC_DROP - 1))) >> FRAC_DROP;
      sat_c[i] = (rnd_c[i] > 64'(NORM_MAX)) ? NORM_MAX : (OUT_W-1)'(rnd_c[i]);
      res_c[i] = d[i][63] ? (~OUT_W'(sat_c[i]) + 1'b1) : OUT_W'(sat_c[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= v2;
    if (en) begin
      degenerate <= dg2;
      normal_x   <= dg2 ? '0 : res_c[0];
      normal_y   <= dg2 ? '0 : res_c[1];
      normal_z   <= dg2 ? '0 : res_c[2];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/triangle_face_normal.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_face_normal
// Face normal of a triangle as the cross product of its two unit edges.
// ----------------------------------------------------------------------------
// Input stream: one triangle per transaction, nine signed Q16.16 coordinates
// in s_axis_tdata. Output stream: one result per triangle, the three Q1.16
// normal components in m_axis_tdata and the degenerate flag in m_axis_tuser.
// A triangle with a zero-length edge reports degenerate with a zero normal.
// From acceptance to m_axis_tvalid a triangle passes one edge stage,
// 70 stages of edge normalization (prescale and squares, a 32-stage square
// root, a 31-stage divider, one bit per stage), and three cross product
// stages ending in the output register. Throughput is one triangle per cycle
// while no result is stalled; all stages advance together.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s_axis_tready drops in the same cycle; nothing is lost or repeated.
// Reset clears every stage's valid bit; the first triangle may be offered
// in the cycle after reset is released.
// ----------------------------------------------------------------------------
module triangle_face_normal (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z, 32 bits each
  input  wire logic [287:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // normal_x [17:0], normal_y [35:18], normal_z [53:36], zero [55:54]
  output logic [55:0]       m_axis_tdata,
  // degenerate
  output logic              m_axis_tuser
);
  import tfn_pkg::*;

  logic            en;
  logic            ev;
  edge3_t          ea, eb;
  tfn_ctl_t        ctl_a, ctl_b;
  unit3_t          ua, ub;
  tfn_ctl_t        cross_ctl;
  logic [OUT_W-1:0] nx, ny, nz;

  // Whole pipeline advances unless the output register holds a stalled result
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  function automatic edge_t sub33(input logic [COORD_W-1:0] p,
                                  input logic [COORD_W-1:0] q);
    return {p[COORD_W-1], p} - {q[COORD_W-1], q};
  endfunction

  always_ff @(posedge clk) begin
    if (rst) ev <= 1'b0;
    else if (en) ev <= s_axis_tvalid;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ea[i] <= sub33(s_axis_tdata[COORD_W*(3+i) +: COORD_W],
                       s_axis_tdata[COORD_W*i +: COORD_W]);
        eb[i] <= sub33(s_axis_tdata[COORD_W*(6+i) +: COORD_W],
                       s_axis_tdata[COORD_W*(3+i) +: COORD_W]);
      end
    end
  end

  tfn_unit u_unit_a (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(ev),
    .e       (ea),
    .out_ctl (ctl_a),
    .u       (ua)
  );

  tfn_unit u_unit_b (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_valid(ev),
    .e       (eb),
    .out_ctl (ctl_b),
    .u       (ub)
  );

  assign cross_ctl.valid = ctl_a.valid;
  assign cross_ctl.zero  = ctl_a.zero || ctl_b.zero;

  tfn_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_ctl    (cross_ctl),
    .ua        (ua),
    .ub        (ub),
    .out_valid (m_axis_tvalid),
    .normal_x  (nx),
    .normal_y  (ny),
    .normal_z  (nz),
    .degenerate(m_axis_tuser)
  );

  assign m_axis_tdata = {2'b00, nz, ny, nx};

  // Both edge units see the same transactions
  a_units_in_step: assert property (@(posedge clk) disable iff (rst)
    ctl_a.valid == ctl_b.valid)
    else $error("edge units out of step");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> (m_axis_tdata[53:0] == '0))
    else $error("degenerate result with nonzero normal");

  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      ($signed(nx) <= 18'sd65536) && ($signed(nx) >= -18'sd65536) &&
      ($signed(ny) <= 18'sd65536) && ($signed(ny) >= -18'sd65536) &&
      ($signed(nz) <= 18'sd65536) && ($signed(nz) >= -18'sd65536))
    else $error("normal component out of range");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result stalled");

endmodule
`default_nettype wire
